// ===== rtl/spwm_pkg.sv =====
// Shared constants, types and state codes for the three-phase SPWM reference block.
`timescale 1ns / 1ps

package spwm_pkg;

    // Default generics
    localparam int SINE_DEPTH_DEFAULT = 1024;
    localparam int PHASE_BITS_DEFAULT = 32;

    // Port widths
    localparam int SAMPLE_W    = 16;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 6 * SAMPLE_W;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 2;
    localparam int LANES       = 3;
    localparam int LANE_W      = 2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MOD_INDEX  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DC_VOLTAGE = 2'd2;

    // Half duty in Q0.16
    localparam logic [SAMPLE_W-1:0] DUTY_HALF = 16'h8000;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 2;

    // Shared multiplier: 17-bit unsigned operand (sign bit zero) by 32-bit signed
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ROM,
        B_MUL1,
        B_MUL2,
        B_FIN,
        B_DONE
    } back_state_t;

endpackage

// ===== rtl/three_phase_spwm_reference.sv =====
// Top level of the three-phase sinusoidal PWM reference generator.
`timescale 1ns / 1ps

// Three-phase SPWM reference generator.
// Input stream: one transaction per sample tick; s_tdata[0] = inverter_on.
//   With inverter_on set, the phase advances by phase_step and the block puts out
//   duties 0.5 + 0.5*mod*sin and references dc*mod*sin/2 for phases A, B (-120 deg)
//   and C (-240 deg). With it clear, the phase and references hold, duties = 0.5.
// Output stream: one transaction per tick; m_tdata packs duty_a/b/c and
//   ref_voltage_a/b/c, 16 bits each, duty_a in the low bits.
// Config: cfg_we/cfg_addr/cfg_wdata, index 0 phase_step, 1 mod_index, 2 dc_voltage;
//   write only while the block is idle. Unknown indexes are dropped.
// Back end: an enabled tick goes through pop, one ROM lead-in, the multiply states
//   B_MUL1 and B_MUL2 for each phase on the single shared 17x32 multiplier, final
//   rounding and output load; a disabled tick goes from pop straight to output load.
// The front end takes one tick per cycle while the 2-entry queue has room, so input
//   keeps flowing while a result waits; when m_tready is low the output register
//   holds, then the queue fills and s_tready drops.
// Reset (aresetn low, synchronous) clears phase, held references, config and queue.
module three_phase_spwm_reference #(
    parameter int SINE_TABLE_DEPTH = spwm_pkg::SINE_DEPTH_DEFAULT,
    parameter int PHASE_BITS       = spwm_pkg::PHASE_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input ticks
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [spwm_pkg::IN_DATA_W-1:0]    s_tdata,   // [0] inverter_on, rest zero
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // duty_a, duty_b, duty_c, ref_voltage_a, ref_voltage_b, ref_voltage_c (LSB up)
    output logic [spwm_pkg::OUT_DATA_W-1:0]   m_tdata,
    // configuration writes
    input  logic                              cfg_we,
    input  logic [spwm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [spwm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
    localparam int ENTRY_W = 1 + 3 * IDX_W;

    logic [spwm_pkg::CFG_DATA_W-1:0] phase_step_reg;
    logic [spwm_pkg::SAMPLE_W-1:0]   mod_index_reg;
    logic [spwm_pkg::SAMPLE_W-1:0]   dc_voltage_reg;

    spwm_pkg::queue_status_t         q_status;
    logic                            q_push;
    logic                            q_pop;
    logic [ENTRY_W-1:0]              q_wdata;
    logic [ENTRY_W-1:0]              q_rdata;
    logic [IDX_W-1:0]                rom_addr;
    logic signed [spwm_pkg::SAMPLE_W-1:0] rom_data;

    // Config registers; writes are registered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg <= '0;
            mod_index_reg  <= '0;
            dc_voltage_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                spwm_pkg::REG_PHASE_STEP: phase_step_reg <= cfg_wdata;
                spwm_pkg::REG_MOD_INDEX:  mod_index_reg  <= cfg_wdata[spwm_pkg::SAMPLE_W-1:0];
                spwm_pkg::REG_DC_VOLTAGE: dc_voltage_reg <= cfg_wdata[spwm_pkg::SAMPLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front: tick intake and phase accumulators
    spwm_front #(
        .PHASE_BITS (PHASE_BITS),
        .IDX_W      (IDX_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .phase_step (phase_step_reg),
        .q_status   (q_status),
        .q_push     (q_push),
        .q_wdata    (q_wdata)
    );

    // Decoupling queue
    spwm_queue #(
        .WIDTH   (ENTRY_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (q_wdata),
        .pop     (q_pop),
        .rd_data (q_rdata),
        .status  (q_status)
    );

    // Sine table
    spwm_sine_rom #(
        .DEPTH   (SINE_TABLE_DEPTH)
    ) u_rom (
        .aclk    (aclk),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    // Back: modulation math and output register
    spwm_back #(
        .IDX_W      (IDX_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_rdata    (q_rdata),
        .q_status   (q_status),
        .q_pop      (q_pop),
        .rom_addr   (rom_addr),
        .rom_data   (rom_data),
        .mod_index  (mod_index_reg),
        .dc_voltage (dc_voltage_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== rtl/spwm_sine_rom.sv =====
// Sine lookup ROM, Q1.15 with amplitude 32767, registered read.
`timescale 1ns / 1ps

module spwm_sine_rom #(
    parameter int DEPTH = spwm_pkg::SINE_DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic [$clog2(DEPTH)-1:0]            rd_addr,
    output logic signed [spwm_pkg::SAMPLE_W-1:0] rd_data
);

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Quarter-wave fold, then a Taylor series in nested form, all Q30
    function automatic logic [spwm_pkg::SAMPLE_W-1:0] sine_entry(input logic [63:0] i);
        logic [63:0] u;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        u  = (i << 32) / 64'(DEPTH);
        q  = (u >> 30) & 64'd3;
        r  = u & (Q30_ONE - 64'd1);
        if (q[0]) begin
            r = Q30_ONE - r;
        end
        x  = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int k = 10; k >= 2; k -= 2) begin
            t = Q30_ONE - (((x2 * t) >> 30) / 64'(k * (k + 1)));
        end
        s = (x * t) >> 30;
        v = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return (q >= 64'd2) ? spwm_pkg::SAMPLE_W'(64'd0 - v) : spwm_pkg::SAMPLE_W'(v);
    endfunction

    function automatic logic [DEPTH-1:0][spwm_pkg::SAMPLE_W-1:0] build_rom();
        logic [DEPTH-1:0][spwm_pkg::SAMPLE_W-1:0] tbl;
        for (int n = 0; n < DEPTH; n++) begin
            tbl[n] = sine_entry(64'(n));
        end
        return tbl;
    endfunction

    localparam logic [DEPTH-1:0][spwm_pkg::SAMPLE_W-1:0] SINE_ROM = build_rom();

    logic [spwm_pkg::SAMPLE_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        data_reg <= SINE_ROM[rd_addr];
    end

    assign rd_data = $signed(data_reg);

endmodule

// ===== rtl/spwm_queue.sv =====
// Small FIFO between the tick front end and the modulation back end.
`timescale 1ns / 1ps

module spwm_queue #(
    parameter int WIDTH = 31
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  logic [WIDTH-1:0]        wr_data,
    input  logic                    pop,
    output logic [WIDTH-1:0]        rd_data,
    output spwm_pkg::queue_status_t status
);

    localparam int DEPTH = spwm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rd_data      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/spwm_front.sv =====
// Tick front end: takes sample ticks, advances the three phase accumulators, queues ROM indexes.
`timescale 1ns / 1ps

module spwm_front #(
    parameter int PHASE_BITS = spwm_pkg::PHASE_BITS_DEFAULT,
    parameter int IDX_W      = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [spwm_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [spwm_pkg::CFG_DATA_W-1:0]   phase_step,
    input  spwm_pkg::queue_status_t           q_status,
    output logic                              q_push,
    output logic [1+3*IDX_W-1:0]              q_wdata
);

    localparam int          SUM_W      = (PHASE_BITS > spwm_pkg::CFG_DATA_W) ?
                                         PHASE_BITS : spwm_pkg::CFG_DATA_W;
    localparam logic [64:0] TURN       = 65'd1 << PHASE_BITS;
    localparam logic [64:0] THIRD      = (TURN + 65'd1) / 65'd3;
    localparam logic [64:0] TWO_THIRDS = (2 * TURN + 65'd1) / 65'd3;
    // lanes B and C run their own accumulators, started one and two thirds behind
    localparam logic [PHASE_BITS-1:0] PH_B_RST = PHASE_BITS'(TURN - THIRD);
    localparam logic [PHASE_BITS-1:0] PH_C_RST = PHASE_BITS'(TURN - TWO_THIRDS);

    logic [PHASE_BITS-1:0] ph_reg  [spwm_pkg::LANES];
    logic [PHASE_BITS-1:0] ph_next [spwm_pkg::LANES];
    logic [SUM_W-1:0]      step_ext;
    logic                  accept;
    logic                  tick_on;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign tick_on  = s_tdata[0];
    assign step_ext = SUM_W'(phase_step);

    always_comb begin
        for (int k = 0; k < spwm_pkg::LANES; k++) begin
            ph_next[k] = ph_reg[k];
            if (accept && tick_on) begin
                ph_next[k] = PHASE_BITS'(SUM_W'(ph_reg[k]) + step_ext);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg[0] <= '0;
            ph_reg[1] <= PH_B_RST;
            ph_reg[2] <= PH_C_RST;
        end else begin
            for (int k = 0; k < spwm_pkg::LANES; k++) begin
                ph_reg[k] <= ph_next[k];
            end
        end
    end

    // Entry layout: bit 0 enable, then lane A, B, C table indexes
    assign q_push  = accept;
    assign q_wdata = {ph_next[2][PHASE_BITS-1 -: IDX_W],
                      ph_next[1][PHASE_BITS-1 -: IDX_W],
                      ph_next[0][PHASE_BITS-1 -: IDX_W],
                      tick_on};

endmodule

// ===== rtl/spwm_back.sv =====
// Modulation back end: per lane ROM read, shared multiplier, rounding, saturation, output register.
`timescale 1ns / 1ps

module spwm_back #(
    parameter int IDX_W = 10
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [1+3*IDX_W-1:0]                 q_rdata,
    input  spwm_pkg::queue_status_t              q_status,
    output logic                                 q_pop,
    output logic [IDX_W-1:0]                     rom_addr,
    input  logic signed [spwm_pkg::SAMPLE_W-1:0] rom_data,
    input  logic [spwm_pkg::SAMPLE_W-1:0]        mod_index,
    input  logic [spwm_pkg::SAMPLE_W-1:0]        dc_voltage,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [spwm_pkg::OUT_DATA_W-1:0]      m_tdata
);

    localparam int SW = spwm_pkg::SAMPLE_W;
    localparam int LW = spwm_pkg::LANE_W;

    spwm_pkg::back_state_t state_reg, state_next;

    logic                  entry_on_reg;
    logic [IDX_W-1:0]      idx_reg [spwm_pkg::LANES];
    logic [LW-1:0]         lane_reg;
    logic [LW-1:0]         rom_lane;
    logic [LW-1:0]         ref_lane;
    logic [SW-1:0]         duty_reg  [spwm_pkg::LANES];
    logic [SW-1:0]         held_refs_reg [spwm_pkg::LANES];
    logic                  out_valid_reg, out_valid_next;
    logic [spwm_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic signed [spwm_pkg::MUL_A_W-1:0] mul_a;
    logic signed [spwm_pkg::MUL_B_W-1:0] mul_b;
    logic signed [spwm_pkg::PROD_W-1:0]  prod_reg;
    logic                                mul_en;
    logic                                duty_we;
    logic                                ref_we;
    logic                                out_load;

    logic signed [spwm_pkg::MUL_B_W-1:0] p_val;
    logic signed [spwm_pkg::MUL_B_W:0]   d_sum;
    logic signed [17:0]                  d_full;
    logic [SW-1:0]                       duty_sat;
    logic signed [spwm_pkg::PROD_W:0]    v_sum;
    logic signed [17:0]                  v_full;
    logic [SW-1:0]                       ref_sat;

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            spwm_pkg::B_IDLE: begin
                if (!q_status.empty) begin
                    state_next = q_rdata[0] ? spwm_pkg::B_ROM : spwm_pkg::B_DONE;
                end
            end
            spwm_pkg::B_ROM:  state_next = spwm_pkg::B_MUL1;
            spwm_pkg::B_MUL1: state_next = spwm_pkg::B_MUL2;
            spwm_pkg::B_MUL2: begin
                state_next = (lane_reg == LW'(spwm_pkg::LANES - 1)) ?
                             spwm_pkg::B_FIN : spwm_pkg::B_MUL1;
            end
            spwm_pkg::B_FIN:  state_next = spwm_pkg::B_DONE;
            spwm_pkg::B_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = spwm_pkg::B_IDLE;
                end
            end
            default:          state_next = spwm_pkg::B_IDLE;
        endcase
    end

    // ---------------- state outputs ----------------
    always_comb begin
        q_pop    = 1'b0;
        mul_en   = 1'b0;
        duty_we  = 1'b0;
        ref_we   = 1'b0;
        out_load = 1'b0;
        mul_a    = $signed({1'b0, mod_index});
        mul_b    = spwm_pkg::MUL_B_W'(rom_data);
        rom_lane = lane_reg;
        ref_lane = lane_reg;
        case (state_reg)
            spwm_pkg::B_IDLE: q_pop = !q_status.empty;
            spwm_pkg::B_ROM:  rom_lane = '0;
            spwm_pkg::B_MUL1: begin
                // mod_index * sine; the previous lane's reference settles alongside
                mul_en   = 1'b1;
                ref_we   = (lane_reg != '0);
                ref_lane = lane_reg - 1'b1;
            end
            spwm_pkg::B_MUL2: begin
                // duty from mod*sine, then dc_voltage * (mod*sine); prefetch next lane
                mul_en   = 1'b1;
                duty_we  = 1'b1;
                mul_a    = $signed({1'b0, dc_voltage});
                mul_b    = p_val;
                rom_lane = (lane_reg == LW'(spwm_pkg::LANES - 1)) ? lane_reg : lane_reg + 1'b1;
            end
            spwm_pkg::B_FIN:  ref_we = 1'b1;
            spwm_pkg::B_DONE: out_load = !out_valid_reg || m_tready;
            default: begin
            end
        endcase
    end

    assign rom_addr = idx_reg[rom_lane];

    // Duty: 32768 + round(mod*s / 2^15), ties away from zero, clamp to 0..65535
    assign p_val  = prod_reg[spwm_pkg::MUL_B_W-1:0];
    assign d_sum  = $signed({p_val[spwm_pkg::MUL_B_W-1], p_val}) + 33'sd16384
                    - $signed({32'd0, p_val[spwm_pkg::MUL_B_W-1]});
    assign d_full = 18'(d_sum >>> 15) + 18'sd32768;

    always_comb begin
        if (d_full < 18'sd0) begin
            duty_sat = '0;
        end else if (d_full > 18'sd65535) begin
            duty_sat = '1;
        end else begin
            duty_sat = d_full[SW-1:0];
        end
    end

    // Reference: round(dc*mod*s / 2^31), ties away from zero, clamp to 16-bit signed
    assign v_sum  = $signed({prod_reg[spwm_pkg::PROD_W-1], prod_reg})
                    + $signed(50'd1 << 30)
                    - $signed({49'd0, prod_reg[spwm_pkg::PROD_W-1]});
    assign v_full = 18'(v_sum >>> 31);

    always_comb begin
        if (v_full > 18'sd32767) begin
            ref_sat = 16'h7FFF;
        end else if (v_full < -18'sd32768) begin
            ref_sat = 16'h8000;
        end else begin
            ref_sat = v_full[SW-1:0];
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= spwm_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
            lane_reg      <= '0;
            for (int k = 0; k < spwm_pkg::LANES; k++) begin
                held_refs_reg[k] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (q_pop) begin
                lane_reg <= '0;
            end else if (state_reg == spwm_pkg::B_MUL2 && state_next == spwm_pkg::B_MUL1) begin
                lane_reg <= lane_reg + 1'b1;
            end
            if (ref_we) begin
                held_refs_reg[ref_lane] <= ref_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            entry_on_reg <= q_rdata[0];
            for (int k = 0; k < spwm_pkg::LANES; k++) begin
                idx_reg[k] <= q_rdata[1 + k*IDX_W +: IDX_W];
                if (!q_rdata[0]) begin
                    duty_reg[k] <= spwm_pkg::DUTY_HALF;
                end
            end
        end
        if (duty_we) begin
            duty_reg[lane_reg] <= duty_sat;
        end
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        if (out_load) begin
            out_data_reg <= {held_refs_reg[2], held_refs_reg[1], held_refs_reg[0],
                             duty_reg[2], duty_reg[1], duty_reg[0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------- checks ----------------
    a_lane_range: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_reg != 2'd3)
        else $error("lane counter out of range");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("pop from empty queue");

    a_mul2_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == spwm_pkg::B_MUL2) |=>
            (state_reg == spwm_pkg::B_MUL1 || state_reg == spwm_pkg::B_FIN))
        else $error("multiply sequence broken");

    a_off_half: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == spwm_pkg::B_DONE && !entry_on_reg) |->
            (duty_reg[0] == spwm_pkg::DUTY_HALF && duty_reg[1] == spwm_pkg::DUTY_HALF &&
             duty_reg[2] == spwm_pkg::DUTY_HALF))
        else $error("disabled tick without half duty");

endmodule

// ===== verif/spwm_reference_checker.sv =====
// Checker for the three-phase SPWM reference block: predicts every tick and compares results.
`timescale 1ns / 1ps

module spwm_reference_checker
    import spwm_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [IN_DATA_W-1:0]    s_tdata,   // [0] inverter_on, rest zero
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    // duty_a, duty_b, duty_c, ref_voltage_a, ref_voltage_b, ref_voltage_c (LSB up)
    input  logic [OUT_DATA_W-1:0]   m_tdata,
    input  logic                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    output int                      mismatch_count,
    output int                      ticks_in_flight
);

    localparam int SINE_DEPTH = SINE_DEPTH_DEFAULT;
    localparam int PHASE_W    = PHASE_BITS_DEFAULT;
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TURN        = 64'd1 << PHASE_W;
    localparam logic [PHASE_W-1:0] THIRD_TURN      = PHASE_W'((TURN + 64'd1) / 64'd3);
    localparam logic [PHASE_W-1:0] TWO_THIRDS_TURN = PHASE_W'((2 * TURN + 64'd1) / 64'd3);

    // laid out like m_tdata: duties in the low half
    typedef struct packed {
        logic [LANES-1:0][SAMPLE_W-1:0] vref;
        logic [LANES-1:0][SAMPLE_W-1:0] duty;
    } tick_result_t;

    logic [PHASE_W-1:0]             phase_acc;
    logic [LANES-1:0][SAMPLE_W-1:0] held_vref;
    logic [31:0]                    step_reg;
    logic [15:0]                    mod_reg;
    logic [15:0]                    dc_reg;
    int                             sine_rom [SINE_DEPTH];
    tick_result_t                   expected_ticks [$];

    // Q1.15 sine of one ROM entry, amplitude 32767, odd Taylor series in Q30
    function automatic int sine_entry(input int unsigned entry);
        longint unsigned turn, quad, frac, x, x2, t, s, v;
        turn = (64'(entry) << 32) / 64'(SINE_DEPTH);
        quad = (turn >> 30) & 64'd3;
        frac = turn & (Q30_ONE - 64'd1);
        if (quad[0]) begin
            frac = Q30_ONE - frac;
        end
        x  = (frac * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int k = 10; k >= 2; k -= 2) begin
            t = Q30_ONE - ((x2 * t) >> 30) / 64'(k * (k + 1));
        end
        s = (x * t) >> 30;
        v = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return quad >= 64'd2 ? -int'(v) : int'(v);
    endfunction

    function automatic longint round_half_away(input longint num, input int sh);
        longint unsigned mag;
        mag = (num < 0) ? 64'(-num) : 64'(num);
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return (num < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // advances the model state by one tick and returns the result it should cause
    function automatic tick_result_t predict_tick(input logic enabled);
        tick_result_t       res;
        logic [PHASE_W-1:0] lane_phase;
        longint             sine, volt, duty;
        if (!enabled) begin
            for (int n = 0; n < LANES; n++) begin
                res.duty[n] = DUTY_HALF;
            end
            res.vref = held_vref;
            return res;
        end
        phase_acc = phase_acc + step_reg;
        for (int n = 0; n < LANES; n++) begin
            lane_phase = phase_acc - (n == 0 ? '0 : (n == 1 ? THIRD_TURN : TWO_THIRDS_TURN));
            sine = sine_rom[(64'(lane_phase) * 64'(SINE_DEPTH)) >> PHASE_W];
            volt = round_half_away(longint'(dc_reg) * longint'(mod_reg) * sine, 31);
            duty = 32768 + round_half_away(longint'(mod_reg) * sine, 15);
            volt = volt > 32767 ? 32767 : (volt < -32768 ? -32768 : volt);
            duty = duty > 65535 ? 65535 : (duty < 0 ? 0 : duty);
            held_vref[n] = volt[15:0];
            res.duty[n]  = duty[15:0];
        end
        res.vref = held_vref;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    initial begin
        for (int i = 0; i < SINE_DEPTH; i++) begin
            sine_rom[i] = sine_entry(i);
        end
    end

    always @(posedge aclk) begin
        tick_result_t got, want;
        if (!aresetn) begin
            mismatch_count = 0;
            phase_acc = '0;
            held_vref = '0;
            step_reg  = '0;
            mod_reg   = '0;
            dc_reg    = '0;
            expected_ticks.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_PHASE_STEP: step_reg = cfg_wdata[31:0];
                    REG_MOD_INDEX:  mod_reg  = cfg_wdata[15:0];
                    REG_DC_VOLTAGE: dc_reg   = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_ticks.size() == 0) begin
                    report_mismatch("result transaction with no tick outstanding");
                end else begin
                    want = expected_ticks.pop_front();
                    for (int n = 0; n < LANES; n++) begin
                        if (got.duty[n] !== want.duty[n]) begin
                            report_mismatch($sformatf("duty_%c got %0d expected %0d",
                                "a" + n, got.duty[n], want.duty[n]));
                        end
                        if (got.vref[n] !== want.vref[n]) begin
                            report_mismatch($sformatf("ref_voltage_%c got %0d expected %0d",
                                "a" + n, $signed(got.vref[n]), $signed(want.vref[n])));
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_ticks.push_back(predict_tick(s_tdata[0]));
            end
        end
        ticks_in_flight <= expected_ticks.size();
    end

endmodule

// ===== verif/three_phase_spwm_reference_tb.sv =====
// Testbench top for the three-phase SPWM reference block: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module three_phase_spwm_reference_tb;
    import spwm_pkg::*;

    // index 3 decodes to nothing; writes there must be dropped
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    localparam int SEGMENTS      = 8;
    localparam int SEGMENT_TICKS = 250;
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off, fills the block
    localparam int STALL_LIMIT   = 2000;  // cycles with no transaction on either side
    localparam int SETTLE_CYCLES = 32;    // well past the tick latency through the block

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata   = '0;   // [0] inverter_on, rest zero
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    // duty_a, duty_b, duty_c, ref_voltage_a, ref_voltage_b, ref_voltage_c (LSB up)
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

    int mismatch_count;
    int ticks_in_flight;

    // flow-control knobs; recv_stall_pct and hold_reqs only change by NBA so the
    // receiver process sees them at a well-defined edge
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_reqs      = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    three_phase_spwm_reference dut (.*);

    spwm_reference_checker checker_i (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: random stalls at the current rate, or a long hold-off on request.
    // One NBA to m_tready per edge.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: a stuck handshake on both sides ends the run.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Offer one tick, with random idle cycles in front, and wait for the transaction.
    // tvalid stays high on return so back-to-back ticks need no extra NBA.
    task automatic send_tick(input logic on);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-1){1'b0}}, on};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Send count ticks, inverter_on taken from pattern LSB first.
    task automatic send_pattern(input logic [7:0] pattern, input int count);
        for (int i = 0; i < count; i++) begin
            send_tick(pattern[i]);
        end
    endtask

    // Stop offering and wait until every predicted result has been seen.
    // The first edge lets the checker count a tick taken at this very edge.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (ticks_in_flight != 0);
    endtask

    // Write all three registers plus the unused index, only with the block idle.
    task automatic program_regs(input logic [31:0] step, input logic [15:0] mod,
                                input logic [15:0] dc);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_PHASE_STEP;
        cfg_wdata <= step;
        @(posedge aclk);
        cfg_addr  <= REG_MOD_INDEX;
        cfg_wdata <= {16'h0, mod};
        @(posedge aclk);
        cfg_addr  <= REG_DC_VOLTAGE;
        cfg_wdata <= {16'h0, dc};
        @(posedge aclk);
        cfg_addr  <= REG_UNUSED;
        cfg_wdata <= $urandom();
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // One random segment. Mode picks the idling: 0 none, 1 sender idle,
    // 2 receiver stalls, 3 both.
    task automatic run_segment(input int mode);
        logic [31:0] step;
        logic [15:0] mod, dc;
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct = 51; recv_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct <= 51; end
            default: begin send_idle_pct = 17; recv_stall_pct <= 17; end
        endcase
        // register values lean on the extremes now and then
        case ($urandom_range(9))
            0: step = 32'h0;
            1: step = 32'hFFFF_FFFF;
            2: step = $urandom_range(1, 32'h0040_0000);   // slow sweep through the ROM
            default: step = $urandom();
        endcase
        case ($urandom_range(9))
            0: mod = 16'd0;
            1: mod = 16'd32768;
            2: mod = $urandom_range(32769, 65535);         // overmodulation, saturates
            default: mod = $urandom_range(0, 32768);
        endcase
        case ($urandom_range(9))
            0: dc = 16'd0;
            1: dc = 16'hFFFF;
            default: dc = $urandom_range(0, 65535);
        endcase
        program_regs(step, mod, dc);
        for (int i = 0; i < SEGMENT_TICKS; i++) begin
            // long receiver hold-off while the sender keeps offering
            if (i == 50 && (mode == 0 || mode == 3)) begin
                hold_reqs <= hold_reqs + 1;
            end
            // sender pause until the block has emptied
            if (i == 150) begin
                wait_drained();
            end
            send_tick($urandom_range(99) < 85);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset defaults, disabled tick before any enabled one
        send_pattern(8'h02, 2);
        // quarter-turn steps: phase wraps to zero, disabled ticks hold refs
        program_regs(32'h4000_0000, 16'd32768, 16'hFFFF);
        send_pattern(8'h5F, 8);
        // largest step, mod above one: duty and reference saturate both ways
        program_regs(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_pattern(8'h07, 4);
        // zero DC link: refs zero, duties still modulated
        program_regs(32'h1234_5678, 16'd32768, 16'h0);
        send_pattern(8'h03, 3);
        // no step, no modulation
        program_regs(32'h0, 16'h0, 16'hFFFF);
        send_pattern(8'h01, 2);

        // Random: every idling mode twice
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            run_segment(seg % 4);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
